>>> rtl/assert_macros.svh
// Assertion macros used by the scheduler core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define PTTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTTS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PTTS_ASSERT(label, clk, rst, prop, msg)
`define PTTS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

>>> rtl/ptts_pkg.sv
`timescale 1ns / 1ps
package ptts_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Command token walking down the slot row, with the result it gathers.
  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [7:0]  task_id;
    logic [2:0]  level;
    logic [15:0] period;
    logic [15:0] start_delay;
    logic        ok;
    logic        dispatched;
    logic [7:0]  dispatch_id;
    logic [2:0]  dispatch_priority;
  } tok_t;

endpackage

>>> rtl/ptts_cell.sv
`timescale 1ns / 1ps
module ptts_cell #(
  parameter int LEVEL = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ptts_pkg::tok_t  tok_in,
  output ptts_pkg::tok_t  tok_out
);

  logic        slot_valid;
  logic [7:0]  slot_task_id;
  logic [15:0] slot_period;
  logic [15:0] slot_delay;

  logic        slot_valid_next;
  logic [7:0]  slot_task_id_next;
  logic [15:0] slot_period_next;
  logic [15:0] slot_delay_next;
  ptts_pkg::tok_t tok_next;
  logic        done;

  assign done = tok_in.ok | tok_in.dispatched;

  always_comb begin
    tok_next          = tok_in;
    slot_valid_next   = slot_valid;
    slot_task_id_next = slot_task_id;
    slot_period_next  = slot_period;
    slot_delay_next   = slot_delay;
    if (tok_in.valid && !done) begin
      unique case (tok_in.cmd)
        ptts_pkg::CMD_TICK: begin
          if (slot_valid) begin
            if (slot_delay == 16'd0) begin
              slot_delay_next            = slot_period - 16'd1;
              tok_next.dispatched        = 1'b1;
              tok_next.dispatch_id       = slot_task_id;
              tok_next.dispatch_priority = 3'(LEVEL);
            end else begin
              slot_delay_next = slot_delay - 16'd1;
            end
          end
        end
        ptts_pkg::CMD_CREATE: begin
          if (!slot_valid && (int'(tok_in.level) == LEVEL)) begin
            slot_valid_next   = 1'b1;
            slot_task_id_next = tok_in.task_id;
            slot_period_next  = tok_in.period;
            slot_delay_next   = tok_in.start_delay;
            tok_next.ok       = 1'b1;
          end
        end
        ptts_pkg::CMD_DELETE: begin
          if (slot_valid && (slot_task_id == tok_in.task_id)) begin
            slot_valid_next = 1'b0;
            tok_next.ok     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (en) begin
      slot_valid <= slot_valid_next;
      tok_out.valid <= tok_next.valid;
    end
    if (en) begin
      slot_task_id              <= slot_task_id_next;
      slot_period               <= slot_period_next;
      slot_delay                <= slot_delay_next;
      tok_out.cmd               <= tok_next.cmd;
      tok_out.task_id           <= tok_next.task_id;
      tok_out.level             <= tok_next.level;
      tok_out.period            <= tok_next.period;
      tok_out.start_delay       <= tok_next.start_delay;
      tok_out.ok                <= tok_next.ok;
      tok_out.dispatched        <= tok_next.dispatched;
      tok_out.dispatch_id       <= tok_next.dispatch_id;
      tok_out.dispatch_priority <= tok_next.dispatch_priority;
    end
  end

endmodule

>>> rtl/priority_tick_task_scheduler_core.sv
`timescale 1ns / 1ps
// Tick scheduler over PRIORITY_LEVELS x SLOTS_PER_LEVEL task slots, one slot per cell
// of a row ordered by level then slot. Each command (tick, create, delete) is taken
// as one transfer and walks the row one cell per cycle unless a held result stalls
// the row; the next command is accepted once the result is in the output register.
// Exactly one result transfer follows every command. No clearing pass after reset.
`include "assert_macros.svh"
module priority_tick_task_scheduler_core #(
  parameter int PRIORITY_LEVELS = 8,
  parameter int SLOTS_PER_LEVEL = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], task_id[9:2], priority_req[12:10], period[28:13],
  // start_delay[44:29], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0], dispatched[1], dispatch_id[9:2], dispatch_priority[12:10], zero fill
  output logic [15:0] m_tdata
);

  localparam int NUM_SLOTS = PRIORITY_LEVELS * SLOTS_PER_LEVEL;

  ptts_pkg::tok_t chain [NUM_SLOTS+1];
  ptts_pkg::tok_t exit_tok;
  logic           busy;
  logic           accept;
  logic           en;
  logic           load;
  logic           out_valid;
  logic           out_ok;
  logic           out_dispatched;
  logic [7:0]     out_dispatch_id;
  logic [2:0]     out_dispatch_priority;
  logic [NUM_SLOTS-1:0] tok_live;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign exit_tok = chain[NUM_SLOTS];
  assign en       = !(exit_tok.valid && out_valid && !m_tready);
  assign load     = en && exit_tok.valid;

  always_comb begin
    chain[0].valid             = accept;
    chain[0].cmd               = s_tdata[1:0];
    chain[0].task_id           = s_tdata[9:2];
    chain[0].level             = s_tdata[12:10];
    chain[0].period            = s_tdata[28:13];
    chain[0].start_delay       = s_tdata[44:29];
    chain[0].ok                = 1'b0;
    chain[0].dispatched        = 1'b0;
    chain[0].dispatch_id       = 8'd0;
    chain[0].dispatch_priority = 3'd0;
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    localparam int Lvl = k / SLOTS_PER_LEVEL;
    ptts_cell #(
      .LEVEL (Lvl)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
    assign tok_live[k] = chain[k+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ok                <= exit_tok.ok;
      out_dispatched        <= exit_tok.dispatched;
      out_dispatch_id       <= exit_tok.dispatch_id;
      out_dispatch_priority <= exit_tok.dispatch_priority;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_dispatch_priority, out_dispatch_id, out_dispatched, out_ok};

  `PTTS_ASSERT(a_single_token, clk, rst, $onehot0(tok_live), "more than one command in the row")
  `PTTS_ASSERT(a_rose_from_exit, clk, rst,
               $rose(m_tvalid) |-> $past(exit_tok.valid),
               "result without a command leaving the row")
  `PTTS_ASSERT_NEVER(a_ok_and_dispatch, clk, rst,
                     exit_tok.valid && exit_tok.ok && exit_tok.dispatched,
                     "ok and dispatch on one command")
  `PTTS_ASSERT(a_dispatch_on_tick, clk, rst,
               (exit_tok.valid && exit_tok.dispatched) |-> (exit_tok.cmd == ptts_pkg::CMD_TICK),
               "dispatch on a non-tick command")
  `PTTS_ASSERT(a_busy_tracks_row, clk, rst, (tok_live != '0) |-> busy,
               "command in the row while idle")

endmodule
